// ===== sv/m3i_pkg.sv =====
// m3i_pkg: shared constant (matrix entry count) for the 3x3 matrix inverse pipeline.
// No dependencies.
package m3i_pkg;
   localparam int unsigned NUM_ENTRIES = 9;
endpackage

// ===== sv/m3i_divider.sv =====
// m3i_divider: pipelined restoring divider, one quotient bit per stage,
// with round-to-nearest and saturation. Depends on m3i_pkg.
module m3i_divider #(
   parameter int unsigned NUM_WIDTH = 128,
   parameter int unsigned DEN_WIDTH = 100,
   parameter int unsigned OUT_WIDTH = 32
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        stall,
   input  logic                        in_valid,
   input  logic signed [NUM_WIDTH-1:0] numer,
   input  logic signed [DEN_WIDTH-1:0] denom,
   output logic signed [OUT_WIDTH-1:0] quot
);
   import m3i_pkg::*;
   localparam int unsigned RW = DEN_WIDTH + 1;
   localparam int unsigned NS = NUM_WIDTH + 1;

   logic [NUM_WIDTH-1:0] n_ff [NS];
   logic [NUM_WIDTH-1:0] q_ff [NS];
   logic [RW-1:0]        r_ff [NS];
   logic [DEN_WIDTH-1:0] d_ff [NS];
   logic                 neg_ff [NS];
   logic                 v_ff [NS];
   logic signed [OUT_WIDTH-1:0] quot_ff;

   // stage 0: magnitudes
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else if (!stall) begin
         v_ff[0] <= in_valid;
      end
      if (!stall) begin
         n_ff[0]   <= numer[NUM_WIDTH-1] ? NUM_WIDTH'(-numer) : NUM_WIDTH'(numer);
         d_ff[0]   <= denom[DEN_WIDTH-1] ? DEN_WIDTH'(-denom) : DEN_WIDTH'(denom);
         neg_ff[0] <= numer[NUM_WIDTH-1] ^ denom[DEN_WIDTH-1];
         q_ff[0]   <= '0;
         r_ff[0]   <= '0;
      end
   end

   for (genvar s = 1; s < NS; s++) begin : g_step
      logic [RW:0] sh_in;
      logic [RW:0] df_in;
      always_comb begin
         sh_in = {r_ff[s-1], n_ff[s-1][NUM_WIDTH-s]};
         df_in = sh_in - (RW+1)'(d_ff[s-1]);
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[s] <= 1'b0;
         end else if (!stall) begin
            v_ff[s] <= v_ff[s-1];
         end
         if (!stall) begin
            n_ff[s]   <= n_ff[s-1];
            d_ff[s]   <= d_ff[s-1];
            neg_ff[s] <= neg_ff[s-1];
            if (!df_in[RW]) begin
               r_ff[s] <= RW'(df_in);
               q_ff[s] <= q_ff[s-1] | (NUM_WIDTH'(1) << (NUM_WIDTH - s));
            end else begin
               r_ff[s] <= RW'(sh_in);
               q_ff[s] <= q_ff[s-1];
            end
         end
      end
   end

   // final: round, saturate, sign
   logic [NUM_WIDTH:0]   qr_in;
   logic [NUM_WIDTH:0]   lim_in;
   logic [NUM_WIDTH:0]   qs_in;
   logic [RW:0]          r2_in;
   always_comb begin
      r2_in  = {r_ff[NS-1], 1'b0};
      qr_in  = {1'b0, q_ff[NS-1]} +
               (NUM_WIDTH+1)'(r2_in >= (RW+1)'(d_ff[NS-1]));
      lim_in = (NUM_WIDTH+1)'(1) << (OUT_WIDTH - 1);
      if (!neg_ff[NS-1]) lim_in = lim_in - (NUM_WIDTH+1)'(1);
      qs_in  = (qr_in > lim_in) ? lim_in : qr_in;
      if (neg_ff[NS-1]) qs_in = -qs_in;
   end
   always_ff @(posedge clock) begin
      if (!stall && v_ff[NS-1]) quot_ff <= OUT_WIDTH'(qs_in);
   end
   assign quot = quot_ff;
endmodule

// ===== sv/m3i_cofactor.sv =====
// m3i_cofactor: six-stage cofactor and determinant computation.
// Depends on m3i_pkg.
module m3i_cofactor #(
   parameter int unsigned DATA_WIDTH = 32
) (
   input  logic                           clock,
   input  logic                           stall,
   input  logic signed [DATA_WIDTH-1:0]   a [m3i_pkg::NUM_ENTRIES],
   output logic signed [2*DATA_WIDTH+1:0] cof [m3i_pkg::NUM_ENTRIES],
   output logic signed [3*DATA_WIDTH+3:0] det
);
   import m3i_pkg::*;
   localparam int unsigned CW = 2*DATA_WIDTH + 2;
   localparam int unsigned DW = 3*DATA_WIDTH + 4;
   localparam int unsigned LW = DATA_WIDTH + 1;

   logic signed [DATA_WIDTH-1:0] a_ff [NUM_ENTRIES];
   logic signed [2*DATA_WIDTH-1:0] p_ff [18];
   logic signed [DATA_WIDTH-1:0] r0_ff [3];
   logic signed [CW-1:0] c_ff [NUM_ENTRIES];
   logic signed [DATA_WIDTH-1:0] r1_ff [3];
   logic signed [2*DATA_WIDTH+1:0] pl_ff [3];
   logic signed [2*DATA_WIDTH:0]   ph_ff [3];
   logic signed [DW-1:0] t_ff [3];
   logic signed [CW-1:0] c2_ff [NUM_ENTRIES];
   logic signed [DW-1:0] det_ff;
   logic signed [CW-1:0] c3_ff [NUM_ENTRIES];
   logic signed [CW-1:0] c4_ff [NUM_ENTRIES];

   always_ff @(posedge clock) begin
      if (!stall) begin
         a_ff <= a;
         p_ff[0]  <= a_ff[4]*a_ff[8]; p_ff[1]  <= a_ff[7]*a_ff[5];
         p_ff[2]  <= a_ff[2]*a_ff[7]; p_ff[3]  <= a_ff[1]*a_ff[8];
         p_ff[4]  <= a_ff[1]*a_ff[5]; p_ff[5]  <= a_ff[2]*a_ff[4];
         p_ff[6]  <= a_ff[5]*a_ff[6]; p_ff[7]  <= a_ff[3]*a_ff[8];
         p_ff[8]  <= a_ff[0]*a_ff[8]; p_ff[9]  <= a_ff[2]*a_ff[6];
         p_ff[10] <= a_ff[3]*a_ff[2]; p_ff[11] <= a_ff[0]*a_ff[5];
         p_ff[12] <= a_ff[3]*a_ff[7]; p_ff[13] <= a_ff[6]*a_ff[4];
         p_ff[14] <= a_ff[6]*a_ff[1]; p_ff[15] <= a_ff[0]*a_ff[7];
         p_ff[16] <= a_ff[0]*a_ff[4]; p_ff[17] <= a_ff[3]*a_ff[1];
         r0_ff <= '{a_ff[0], a_ff[1], a_ff[2]};
         for (int i = 0; i < NUM_ENTRIES; i++) begin
            c_ff[i] <= CW'(p_ff[2*i]) - CW'(p_ff[2*i+1]);
         end
         r1_ff <= r0_ff;
         // first-row terms: cofactor split into unsigned low and signed high halves
         for (int k = 0; k < 3; k++) begin
            pl_ff[k] <= r1_ff[k] * $signed({1'b0, c_ff[3*k][LW-1:0]});
            ph_ff[k] <= r1_ff[k] * $signed(c_ff[3*k][CW-1:LW]);
         end
         c2_ff <= c_ff;
         for (int k = 0; k < 3; k++) begin
            t_ff[k] <= (DW'(ph_ff[k]) <<< LW) + DW'(pl_ff[k]);
         end
         c3_ff <= c2_ff;
         det_ff <= t_ff[0] + t_ff[1] + t_ff[2];
         c4_ff <= c3_ff;
      end
   end
   assign cof = c4_ff;
   assign det = det_ff;
endmodule

// ===== sv/matrix3x3_inverse.sv =====
// matrix3x3_inverse: top level of the pipelined 3x3 fixed-point inverse.
// Depends on m3i_pkg, m3i_cofactor, m3i_divider.
//
// Usage: one matrix (nine signed Q entries, row major) enters per req_
// transaction; one rsp_ transaction returns the nine inverse entries and
// a singular flag. The inverse is adjugate / determinant, each entry the
// exact quotient rounded to nearest (ties away from zero), saturated.
// A zero determinant sets singular and forces all entries to zero.
// Pipeline: 6 register stages for cofactors and determinant (the first
// loads at the accepting edge), then the divider (numerator width + 2
// stages, one quotient bit per stage), plus one output register.
// Throughput: one transaction per cycle while not stalled; the nine dividers run in parallel.
// Stall: the whole pipeline freezes while the output register holds an
// unaccepted result; req_ready is low only then, so nothing is lost.
// Reset: clears all valid bits; payload registers are not reset.
module matrix3x3_inverse #(
   parameter int unsigned DATA_WIDTH = 32,
   parameter int unsigned FRAC_BITS  = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic signed [DATA_WIDTH-1:0] req_a00, req_a01, req_a02,
   input  logic signed [DATA_WIDTH-1:0] req_a10, req_a11, req_a12,
   input  logic signed [DATA_WIDTH-1:0] req_a20, req_a21, req_a22,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic signed [DATA_WIDTH-1:0] rsp_inv00, rsp_inv01, rsp_inv02,
   output logic signed [DATA_WIDTH-1:0] rsp_inv10, rsp_inv11, rsp_inv12,
   output logic signed [DATA_WIDTH-1:0] rsp_inv20, rsp_inv21, rsp_inv22,
   output logic                         rsp_singular
);
   import m3i_pkg::*;
   localparam int unsigned CW = 2*DATA_WIDTH + 2;
   localparam int unsigned DW = 3*DATA_WIDTH + 4;
   localparam int unsigned NW = CW + 2*FRAC_BITS;
   localparam int unsigned FRONT = 6;
   localparam int unsigned DIV_LAT = NW + 2;
   localparam int unsigned LAT = FRONT + DIV_LAT;

   logic stall;
   logic signed [DATA_WIDTH-1:0] a_in [NUM_ENTRIES];
   logic signed [CW-1:0] cof [NUM_ENTRIES];
   logic signed [DW-1:0] det;
   logic signed [DATA_WIDTH-1:0] quot [NUM_ENTRIES];
   logic [LAT-1:0] v_ff;
   logic [DIV_LAT-1:0] sing_ff;
   logic rsp_valid_ff;
   logic rsp_singular_ff;
   logic signed [DATA_WIDTH-1:0] inv_ff [NUM_ENTRIES];

   // pipeline advances unless the output register holds a stalled result
   assign stall     = rsp_valid_ff && !rsp_ready;
   assign req_ready = !stall;
   assign a_in = '{req_a00, req_a01, req_a02, req_a10, req_a11, req_a12,
                   req_a20, req_a21, req_a22};

   m3i_cofactor #(.DATA_WIDTH(DATA_WIDTH)) u_cof (
      .clock(clock), .stall(stall), .a(a_in), .cof(cof), .det(det));

   for (genvar i = 0; i < NUM_ENTRIES; i++) begin : g_div
      m3i_divider #(.NUM_WIDTH(NW), .DEN_WIDTH(DW), .OUT_WIDTH(DATA_WIDTH)) u_div (
         .clock(clock), .reset(reset), .stall(stall),
         .in_valid(v_ff[FRONT-1]),
         .numer({cof[i], {(2*FRAC_BITS){1'b0}}}),
         // a zero determinant is replaced by one to keep the divider sane
         .denom((det == '0) ? DW'(1) : det),
         .quot(quot[i]));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (!stall) begin
         v_ff         <= {v_ff[LAT-2:0], req_valid};
         rsp_valid_ff <= v_ff[LAT-1];
      end
      if (!stall) begin
         sing_ff <= {sing_ff[DIV_LAT-2:0], det == '0};
         if (v_ff[LAT-1]) begin
            rsp_singular_ff <= sing_ff[DIV_LAT-1];
            for (int i = 0; i < NUM_ENTRIES; i++) begin
               inv_ff[i] <= sing_ff[DIV_LAT-1] ? '0 : quot[i];
            end
         end
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_singular = rsp_singular_ff;
   assign rsp_inv00 = inv_ff[0]; assign rsp_inv01 = inv_ff[1];
   assign rsp_inv02 = inv_ff[2]; assign rsp_inv10 = inv_ff[3];
   assign rsp_inv11 = inv_ff[4]; assign rsp_inv12 = inv_ff[5];
   assign rsp_inv20 = inv_ff[6]; assign rsp_inv21 = inv_ff[7];
   assign rsp_inv22 = inv_ff[8];
endmodule

// ===== sv/m3i_checker.sv =====
// m3i_checker: port-level assertions for matrix3x3_inverse, with bind.
// Depends on matrix3x3_inverse ports only.
module m3i_checker #(
   parameter int unsigned DATA_WIDTH = 32
) (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_ready,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input logic                  rsp_singular,
   input logic [DATA_WIDTH-1:0] rsp_inv00,
   input logic [DATA_WIDTH-1:0] rsp_inv22
);
   a_ready_stall: assert property (@(posedge clock) disable iff (reset)
      req_ready == !(rsp_valid && !rsp_ready))
      else $error("req_ready does not follow output stall");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_inv00))
      else $error("stalled result changed");
   a_sing_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_singular |-> rsp_inv00 == '0 && rsp_inv22 == '0)
      else $error("singular result has nonzero entries");
   a_reset: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("valid after reset");
endmodule

bind matrix3x3_inverse m3i_checker #(.DATA_WIDTH(DATA_WIDTH)) u_m3i_checker (
   .clock(clock), .reset(reset), .req_ready(req_ready),
   .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_singular(rsp_singular),
   .rsp_inv00(rsp_inv00), .rsp_inv22(rsp_inv22));
